### src/ffpa_pkg.sv
package ffpa_pkg;

  localparam int unsigned PoolBytes   = 4096;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned FieldW      = 13;
  localparam int unsigned PtrW        = 14;
  localparam int unsigned MemAw       = 12;
  localparam int unsigned CountW      = 10;

  localparam logic TagFree  = 1'b0;
  localparam logic TagUsing = 1'b1;

  localparam logic [2:0] ReqAlloc    = 3'd0;
  localparam logic [2:0] ReqFree     = 3'd1;
  localparam logic [2:0] ReqFreeSafe = 3'd2;
  localparam logic [2:0] ReqMergeAll = 3'd3;
  localparam logic [2:0] ReqMergeAt  = 3'd4;
  localparam logic [2:0] ReqValidate = 3'd5;
  localparam logic [2:0] ReqInspect  = 3'd6;
  localparam logic [2:0] ReqCount    = 3'd7;

  localparam logic CfgPoolSize  = 1'b0;
  localparam logic CfgAutoMerge = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_CUR_H,
    CMD_RD_CUR,
    CMD_RD_NX,
    CMD_ROVER_ALLOC,
    CMD_STEP,
    CMD_ALLOC_TAKE,
    CMD_ALLOC_SPLIT,
    CMD_FREE_WR,
    CMD_SAVE,
    CMD_MERGE,
    CMD_STEP_NX,
    CMD_VAL_OK,
    CMD_INSPECT
  } cmd_e;

  typedef struct packed {
    logic size_zero;
    logic rover_fits;
    logic cur_eq_rover;
    logic cur_gt_rover;
    logic cur_eq_tgt;
    logic cur_gt_tgt;
    logic addr_lo;
    logic addressable;
    logic h_is_rover;
    logic addr_zero;
    logic rover_zero;
    logic rd_fit;
    logic rd_split;
    logic nxt_gt_rover;
    logic both_free;
    logic nx_eq_rover;
    logic auto_merge;
  } stat_t;

endpackage

### src/ffpa_datapath.sv
module ffpa_datapath
  import ffpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  output stat_t               stat_o,
  input  logic [2:0]          req_type_i,
  input  logic [11:0]         req_size_i,
  input  logic [FieldW-1:0]   block_addr_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [FieldW-1:0]   cfg_data_i,
  output logic                ok_o,
  output logic [FieldW-1:0]   result_addr_o,
  output logic [FieldW-1:0]   block_size_o,
  output logic                block_free_o,
  output logic                in_range_o,
  output logic [CountW-1:0]   block_count_o,
  output logic [FieldW-1:0]   free_total_o,
  output logic [FieldW-1:0]   rover_free_o
);

  localparam logic [PtrW-1:0]   Hdr14   = PtrW'(HeaderBytes);
  localparam logic [FieldW-1:0] Hdr13   = FieldW'(HeaderBytes);
  localparam logic [PtrW-1:0]   Pool14  = PtrW'(PoolBytes);
  localparam logic [FieldW-1:0] PoolMax = FieldW'(PoolBytes);
  localparam logic [FieldW-1:0] PoolMin = FieldW'(2 * HeaderBytes);

  logic [FieldW:0] mem [PoolBytes];

  logic [FieldW-1:0] rover_q, rsz_q, avail_q, pool_q;
  logic              am_q;
  logic [2:0]        type_q;
  logic [11:0]       size_q;
  logic [FieldW-1:0] addr_q;
  logic [PtrW-1:0]   cur_q, nx_q;
  logic [FieldW-1:0] cs_q;
  logic              ct_q;
  logic              ok_q, bfree_q, inr_q;
  logic [FieldW-1:0] raddr_q, bsize_q;
  logic [CountW-1:0] cnt_q;
  logic [FieldW:0]   rdata_q;
  logic              rd_ovr_q, rd_oob_q;

  logic [FieldW-1:0] pool_eff, cfg_eff, rd_sz, real_sz, rover13, h13;
  logic              rd_tg;
  logic [PtrW-1:0]   rd_addr, cur_nxt, rover14, tgt, rem;
  logic              rd_en, wr_en;
  logic [PtrW-1:0]   wr_addr;
  logic [FieldW:0]   wr_data;
  logic [FieldW-1:0] merged_sz;

  function automatic logic [FieldW-1:0] clamp_pool(input logic [FieldW-1:0] p);
    logic [FieldW-1:0] r;
    r = p;
    if (p < PoolMin) r = PoolMin;
    if (p > PoolMax) r = PoolMax;
    return r;
  endfunction

  function automatic logic [FieldW-1:0] sat_add(input logic [FieldW-1:0] a,
                                                 input logic [FieldW-1:0] b);
    logic [FieldW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FieldW] ? {FieldW{1'b1}} : s[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] sat_sub(input logic [FieldW-1:0] a,
                                                 input logic [FieldW-1:0] b);
    return (a < b) ? '0 : a - b;
  endfunction

  assign pool_eff  = clamp_pool(pool_q);
  assign cfg_eff   = clamp_pool(cfg_data_i);
  assign rover14   = {1'b0, rover_q};
  assign rover13   = rover_q;
  assign real_sz   = {1'b0, size_q} + Hdr13;
  assign tgt       = {1'b0, addr_q} - Hdr14;
  assign h13       = addr_q - Hdr13;
  assign rd_sz     = rd_oob_q ? '0 : (rd_ovr_q ? rsz_q : rdata_q[FieldW-1:0]);
  assign rd_tg     = (rd_oob_q || rd_ovr_q) ? TagFree : rdata_q[FieldW];
  assign cur_nxt   = cur_q + Hdr14 + {1'b0, rd_sz};
  assign rem       = cur_q + Hdr14 + PtrW'(size_q);
  assign merged_sz = cs_q + rd_sz + Hdr13;

  assign stat_o.size_zero    = (size_q == '0);
  assign stat_o.rover_fits   = (rsz_q >= real_sz);
  assign stat_o.cur_eq_rover = (cur_q == rover14);
  assign stat_o.cur_gt_rover = (cur_q > rover14);
  assign stat_o.cur_eq_tgt   = (cur_q == tgt);
  assign stat_o.cur_gt_tgt   = (cur_q > tgt);
  assign stat_o.addr_lo      = (addr_q < Hdr13);
  assign stat_o.addressable  = (addr_q >= Hdr13) && (addr_q <= pool_eff);
  assign stat_o.h_is_rover   = (h13 == rover13);
  assign stat_o.addr_zero    = (addr_q == '0);
  assign stat_o.rover_zero   = (rover_q == '0);
  assign stat_o.rd_fit       = (rd_tg == TagFree) && (rd_sz >= FieldW'(size_q));
  assign stat_o.rd_split     = (rd_sz > real_sz);
  assign stat_o.nxt_gt_rover = (cur_nxt > rover14);
  assign stat_o.both_free    = (ct_q == TagFree) && (rd_tg == TagFree);
  assign stat_o.nx_eq_rover  = (nx_q == rover14);
  assign stat_o.auto_merge   = am_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = '0;
    unique case (cmd_i)
      CMD_RD_CUR: begin
        rd_en = 1'b1;
      end
      CMD_RD_NX: begin
        rd_en   = 1'b1;
        rd_addr = nx_q;
      end
      CMD_ROVER_ALLOC: begin
        wr_en   = 1'b1;
        wr_addr = rover14;
        wr_data = {TagUsing, FieldW'(size_q)};
      end
      CMD_ALLOC_TAKE: begin
        wr_en   = 1'b1;
        wr_data = {TagUsing, (rd_sz > real_sz) ? FieldW'(size_q) : rd_sz};
      end
      CMD_ALLOC_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = rem;
        wr_data = {TagFree, cs_q - real_sz};
      end
      CMD_FREE_WR: begin
        wr_en   = (cur_q != rover14);
        wr_data = {TagFree, rd_sz};
      end
      CMD_MERGE: begin
        wr_en   = 1'b1;
        wr_data = {TagFree, merged_sz};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr < Pool14)) begin
      mem[wr_addr[MemAw-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem[rd_addr[MemAw-1:0]];
      rd_ovr_q <= (rd_addr == rover14);
      rd_oob_q <= (rd_addr >= Pool14);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= '0;
      rsz_q   <= PoolMax - Hdr13;
      avail_q <= PoolMax - Hdr13;
      pool_q  <= PoolMax;
      am_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPoolSize: begin
            pool_q  <= cfg_data_i;
            rover_q <= '0;
            rsz_q   <= cfg_eff - Hdr13;
            avail_q <= cfg_eff - Hdr13;
          end
          CfgAutoMerge: am_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      unique case (cmd_i)
        CMD_ROVER_ALLOC: begin
          rover_q <= rover_q + real_sz;
          rsz_q   <= rsz_q - real_sz;
          avail_q <= sat_sub(avail_q, real_sz);
        end
        CMD_ALLOC_TAKE:  avail_q <= sat_sub(avail_q, rd_sz);
        CMD_ALLOC_SPLIT: avail_q <= sat_add(avail_q, cs_q - real_sz);
        CMD_FREE_WR:     avail_q <= sat_add(avail_q, rd_sz);
        CMD_MERGE: begin
          avail_q <= sat_add(avail_q, Hdr13);
          if (nx_q == rover14) begin
            rover_q <= cur_q[FieldW-1:0];
            rsz_q   <= merged_sz;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        type_q  <= req_type_i;
        size_q  <= req_size_i;
        addr_q  <= block_addr_i;
        cur_q   <= '0;
        ok_q    <= 1'b0;
        raddr_q <= '0;
        bsize_q <= '0;
        bfree_q <= 1'b0;
        inr_q   <= (req_type_i == ReqInspect) && (block_addr_i < pool_eff);
        cnt_q   <= '0;
      end
      CMD_SET_CUR_H: cur_q <= {1'b0, h13};
      CMD_ROVER_ALLOC: begin
        ok_q    <= 1'b1;
        raddr_q <= rover_q + Hdr13;
      end
      CMD_STEP: begin
        cur_q <= cur_nxt;
        cnt_q <= cnt_q + 1'b1;
      end
      CMD_ALLOC_TAKE: begin
        cs_q    <= rd_sz;
        ok_q    <= 1'b1;
        raddr_q <= cur_q[FieldW-1:0] + Hdr13;
      end
      CMD_FREE_WR: begin
        ok_q  <= 1'b1;
        cur_q <= '0;
      end
      CMD_SAVE: begin
        cs_q <= rd_sz;
        ct_q <= rd_tg;
        nx_q <= cur_nxt;
      end
      CMD_MERGE:   ok_q  <= 1'b1;
      CMD_STEP_NX: cur_q <= nx_q;
      CMD_VAL_OK:  ok_q  <= 1'b1;
      CMD_INSPECT: begin
        bsize_q <= rd_sz;
        bfree_q <= (rd_tg == TagFree);
        if (addr_q == '0) begin
          raddr_q <= Hdr13;
        end else begin
          raddr_q <= (cur_nxt == rover14) ? '0 : cur_nxt[FieldW-1:0] + Hdr13;
        end
      end
      default: begin
      end
    endcase
  end

  assign ok_o          = ok_q;
  assign result_addr_o = raddr_q;
  assign block_size_o  = bsize_q;
  assign block_free_o  = bfree_q;
  assign in_range_o    = inr_q;
  assign block_count_o = (type_q == ReqCount) ? cnt_q : '0;
  assign free_total_o  = avail_q;
  assign rover_free_o  = rsz_q;

endmodule

### src/ffpa_ctrl.sv
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_e       cmd_o,
  output logic       busy,
  output logic       done_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_AW_CHK = 5'd2;
  localparam logic [4:0] S_AW_EV  = 5'd3;
  localparam logic [4:0] S_AW_SPL = 5'd4;
  localparam logic [4:0] S_FR_RD  = 5'd5;
  localparam logic [4:0] S_FR_WR  = 5'd6;
  localparam logic [4:0] S_VA_CHK = 5'd7;
  localparam logic [4:0] S_VA_EV  = 5'd8;
  localparam logic [4:0] S_MA_CHK = 5'd9;
  localparam logic [4:0] S_MA_SV  = 5'd10;
  localparam logic [4:0] S_MA_RDN = 5'd11;
  localparam logic [4:0] S_MA_EV  = 5'd12;
  localparam logic [4:0] S_MT_RD  = 5'd13;
  localparam logic [4:0] S_MT_SV  = 5'd14;
  localparam logic [4:0] S_MT_RDN = 5'd15;
  localparam logic [4:0] S_MT_EV  = 5'd16;
  localparam logic [4:0] S_IN_RD  = 5'd17;
  localparam logic [4:0] S_IN_EV  = 5'd18;
  localparam logic [4:0] S_CN_CHK = 5'd19;
  localparam logic [4:0] S_CN_EV  = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  logic [4:0] state_q, state_d;
  logic [2:0] type_q, type_d;

  always_comb begin
    state_d = state_q;
    type_d  = type_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = CMD_LOAD;
          type_d  = req_type_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (type_q)
          ReqAlloc: begin
            if (stat_i.size_zero) begin
              state_d = S_DONE;
            end else if (stat_i.rover_fits) begin
              cmd_o   = CMD_ROVER_ALLOC;
              state_d = S_DONE;
            end else begin
              state_d = S_AW_CHK;
            end
          end
          ReqFree: begin
            if (stat_i.addressable) begin
              cmd_o   = CMD_SET_CUR_H;
              state_d = S_FR_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          ReqFreeSafe, ReqValidate: begin
            state_d = stat_i.addr_lo ? S_DONE : S_VA_CHK;
          end
          ReqMergeAll: state_d = S_MA_CHK;
          ReqMergeAt: begin
            if (stat_i.addressable && !stat_i.h_is_rover) begin
              cmd_o   = CMD_SET_CUR_H;
              state_d = S_MT_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          ReqInspect: begin
            if (stat_i.addr_zero) begin
              state_d = stat_i.rover_zero ? S_DONE : S_IN_RD;
            end else if (stat_i.addressable) begin
              cmd_o   = CMD_SET_CUR_H;
              state_d = S_IN_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_CN_CHK;
        endcase
      end
      S_AW_CHK: begin
        if (stat_i.cur_eq_rover || stat_i.cur_gt_rover) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_CUR;
          state_d = S_AW_EV;
        end
      end
      S_AW_EV: begin
        if (stat_i.rd_fit) begin
          cmd_o   = CMD_ALLOC_TAKE;
          state_d = stat_i.rd_split ? S_AW_SPL : S_DONE;
        end else begin
          cmd_o   = CMD_STEP;
          state_d = S_AW_CHK;
        end
      end
      S_AW_SPL: begin
        cmd_o   = CMD_ALLOC_SPLIT;
        state_d = S_DONE;
      end
      S_FR_RD: begin
        cmd_o   = CMD_RD_CUR;
        state_d = S_FR_WR;
      end
      S_FR_WR: begin
        cmd_o   = CMD_FREE_WR;
        state_d = stat_i.auto_merge ? S_MA_CHK : S_DONE;
      end
      S_VA_CHK: begin
        priority if (stat_i.cur_eq_rover || stat_i.cur_gt_tgt) begin
          state_d = S_DONE;
        end else if (stat_i.cur_eq_tgt) begin
          if (type_q == ReqValidate) begin
            cmd_o   = CMD_VAL_OK;
            state_d = S_DONE;
          end else if (stat_i.addressable) begin
            cmd_o   = CMD_SET_CUR_H;
            state_d = S_FR_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.cur_gt_rover) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_CUR;
          state_d = S_VA_EV;
        end
      end
      S_VA_EV: begin
        cmd_o   = CMD_STEP;
        state_d = S_VA_CHK;
      end
      S_MA_CHK: begin
        if (stat_i.cur_eq_rover || stat_i.cur_gt_rover) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_CUR;
          state_d = S_MA_SV;
        end
      end
      S_MA_SV: begin
        cmd_o   = CMD_SAVE;
        state_d = stat_i.nxt_gt_rover ? S_DONE : S_MA_RDN;
      end
      S_MA_RDN: begin
        cmd_o   = CMD_RD_NX;
        state_d = S_MA_EV;
      end
      S_MA_EV: begin
        if (stat_i.both_free) begin
          cmd_o   = CMD_MERGE;
          state_d = stat_i.nx_eq_rover ? S_DONE : S_MA_CHK;
        end else begin
          cmd_o   = CMD_STEP_NX;
          state_d = S_MA_CHK;
        end
      end
      S_MT_RD: begin
        cmd_o   = CMD_RD_CUR;
        state_d = S_MT_SV;
      end
      S_MT_SV: begin
        cmd_o   = CMD_SAVE;
        state_d = S_MT_RDN;
      end
      S_MT_RDN: begin
        cmd_o   = CMD_RD_NX;
        state_d = S_MT_EV;
      end
      S_MT_EV: begin
        if (stat_i.both_free) begin
          cmd_o = CMD_MERGE;
        end
        state_d = S_DONE;
      end
      S_IN_RD: begin
        cmd_o   = CMD_RD_CUR;
        state_d = S_IN_EV;
      end
      S_IN_EV: begin
        cmd_o   = CMD_INSPECT;
        state_d = S_DONE;
      end
      S_CN_CHK: begin
        if (stat_i.cur_eq_rover || stat_i.cur_gt_rover) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_CUR;
          state_d = S_CN_EV;
        end
      end
      S_CN_EV: begin
        cmd_o   = CMD_STEP;
        state_d = S_CN_CHK;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      type_q  <= ReqAlloc;
    end else begin
      state_q <= state_d;
      type_q  <= type_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted transaction not started");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("block did not return to idle after result");

endmodule

### src/first_fit_pool_allocator.sv
// First-fit pool allocator with a tail free region (rover).
// A transaction is accepted at a rising clock edge with start high and busy
// low; req_type_i, req_size_i and block_addr_i are sampled at that edge.
// The block raises busy until the transaction completes. The result is shown
// on the output ports for exactly one cycle, marked by done_o; the receiver
// cannot stall it and must take it in that cycle.
// An allocation from the rover and a request rejected at once finish
// straight from dispatch; inspect and plain free read one header and then
// act on it, and a merge at one block reads its header and the next one.
// Allocation, validation and count walk the header chain through one memory
// read port, reading one header per block visited; a merge of all pairs
// reads two headers per block visited or pair joined, and a free with auto
// merge adds such a pass. busy stays high in the result cycle, so the next
// transaction is accepted in the cycle after it at the earliest.
// Configuration writes take effect at once and must only occur while idle.
// After reset the pool spans 4096 bytes as one free region and auto merge is
// off; writing the pool size reinitializes the pool the same way.
// Header memory is not cleared; a free, merge at or inspect may read stale data.
module first_fit_pool_allocator
  import ffpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type_i,
  input  logic [11:0]       req_size_i,
  input  logic [FieldW-1:0] block_addr_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [FieldW-1:0] cfg_data_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [FieldW-1:0] result_addr_o,
  output logic [FieldW-1:0] block_size_o,
  output logic              block_free_o,
  output logic              in_range_o,
  output logic [CountW-1:0] block_count_o,
  output logic [FieldW-1:0] free_total_o,
  output logic [FieldW-1:0] rover_free_o
);

  cmd_e  cmd;
  stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o)
  );

  ffpa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .req_size_i    (req_size_i),
    .block_addr_i  (block_addr_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .ok_o          (ok_o),
    .result_addr_o (result_addr_o),
    .block_size_o  (block_size_o),
    .block_free_o  (block_free_o),
    .in_range_o    (in_range_o),
    .block_count_o (block_count_o),
    .free_total_o  (free_total_o),
    .rover_free_o  (rover_free_o)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ffpa_pkg::*;

  localparam int unsigned CycleLimit = 40000000;

  typedef struct packed {
    logic              ok;
    logic [FieldW-1:0] raddr;
    logic [FieldW-1:0] bsize;
    logic              bfree;
    logic              inr;
    logic [CountW-1:0] cnt;
    logic [FieldW-1:0] ftotal;
    logic [FieldW-1:0] rfree;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        req_type_i;
  logic [11:0]       req_size_i;
  logic [FieldW-1:0] block_addr_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [FieldW-1:0] cfg_data_i;
  logic              done_o;
  logic              ok_o;
  logic [FieldW-1:0] result_addr_o;
  logic [FieldW-1:0] block_size_o;
  logic              block_free_o;
  logic              in_range_o;
  logic [CountW-1:0] block_count_o;
  logic [FieldW-1:0] free_total_o;
  logic [FieldW-1:0] rover_free_o;

  first_fit_pool_allocator DUT (.*);

  logic [FieldW-1:0] hdr_sz [PoolBytes];
  logic              hdr_tag [PoolBytes];
  int unsigned       rover_at;
  int unsigned       avail_b;
  int unsigned       rover_b;
  int unsigned       pool_cfg;
  logic              merge_on;

  outcome_t    pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic int unsigned pool_span();
    int unsigned p;
    p = pool_cfg;
    if (p < 2 * HeaderBytes) p = 2 * HeaderBytes;
    if (p > PoolBytes) p = PoolBytes;
    return p;
  endfunction

  function automatic int unsigned size_of(int unsigned h);
    return h < PoolBytes ? int'(hdr_sz[h]) : 0;
  endfunction

  function automatic logic tag_of(int unsigned h);
    return h < PoolBytes ? hdr_tag[h] : TagFree;
  endfunction

  function automatic void put_hdr(int unsigned h, int unsigned sz, logic tg);
    if (h < PoolBytes) begin
      hdr_sz[h] = sz[FieldW-1:0];
      hdr_tag[h] = tg;
    end
  endfunction

  function automatic int unsigned follow(int unsigned h);
    return h + HeaderBytes + size_of(h);
  endfunction

  function automatic void gain(int unsigned x);
    avail_b = avail_b + x;
    if (avail_b > 8191) avail_b = 8191;
  endfunction

  function automatic void spend(int unsigned x);
    avail_b = avail_b < x ? 0 : avail_b - x;
  endfunction

  function automatic void reinit_pool();
    rover_at = 0;
    avail_b = pool_span() - HeaderBytes;
    rover_b = avail_b;
    put_hdr(0, avail_b, TagFree);
  endfunction

  function automatic logic has_header(int unsigned a);
    return a >= HeaderBytes && a <= pool_span();
  endfunction

  function automatic logic join_all();
    int unsigned cur, nx, steps, merged;
    cur = 0;
    steps = 0;
    merged = 0;
    while (cur != rover_at && steps < PoolBytes) begin
      steps++;
      if (cur > rover_at) break;
      nx = follow(cur);
      if (nx > rover_at) break;
      if (tag_of(cur) != TagFree || tag_of(nx) != TagFree) begin
        cur = nx;
        continue;
      end
      gain(HeaderBytes);
      put_hdr(cur, size_of(cur) + size_of(nx) + HeaderBytes, TagFree);
      merged++;
      if (nx == rover_at) begin
        rover_at = cur;
        rover_b = size_of(cur);
        break;
      end
    end
    return merged != 0;
  endfunction

  function automatic logic release_blk(int unsigned a);
    int unsigned h;
    if (!has_header(a)) return 1'b0;
    h = a - HeaderBytes;
    put_hdr(h, size_of(h), TagFree);
    gain(size_of(h));
    if (merge_on) void'(join_all());
    return 1'b1;
  endfunction

  function automatic logic on_chain(int unsigned a);
    int unsigned t, head, steps;
    if (a < HeaderBytes) return 1'b0;
    t = a - HeaderBytes;
    head = 0;
    steps = 0;
    while (head != rover_at && steps < PoolBytes) begin
      steps++;
      if (head > t) return 1'b0;
      if (head == t) return 1'b1;
      if (head > rover_at) return 1'b0;
      head = follow(head);
    end
    return 1'b0;
  endfunction

  function automatic logic join_at(int unsigned a);
    int unsigned h, nx;
    if (!has_header(a)) return 1'b0;
    h = a - HeaderBytes;
    if (h == rover_at) return 1'b0;
    nx = follow(h);
    if (tag_of(h) != TagFree || tag_of(nx) != TagFree) return 1'b0;
    gain(HeaderBytes);
    put_hdr(h, size_of(h) + size_of(nx) + HeaderBytes, TagFree);
    if (nx == rover_at) begin
      rover_at = h;
      rover_b = size_of(h);
    end
    return 1'b1;
  endfunction

  function automatic logic carve(int unsigned sz, output int unsigned a);
    int unsigned full, cur, steps, cs, res, nr;
    full = sz + HeaderBytes;
    cur = 0;
    steps = 0;
    a = 0;
    if (sz == 0) return 1'b0;
    if (size_of(rover_at) >= full) begin
      res = rover_at;
      nr = (rover_at + full) & 13'h1fff;
      put_hdr(nr, size_of(res) - full, TagFree);
      put_hdr(res, sz, TagUsing);
      spend(full);
      rover_at = nr;
      rover_b = size_of(nr);
      a = res + HeaderBytes;
      return 1'b1;
    end
    while (cur != rover_at && steps < PoolBytes) begin
      steps++;
      if (cur > rover_at) break;
      cs = size_of(cur);
      if (tag_of(cur) != TagFree || cs < sz) begin
        cur = follow(cur);
        continue;
      end
      put_hdr(cur, cs, TagUsing);
      spend(cs);
      a = cur + HeaderBytes;
      if (cs <= full) return 1'b1;
      put_hdr(cur + HeaderBytes + sz, cs - full, TagFree);
      gain(cs - full);
      put_hdr(cur, sz, TagUsing);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t apply_request(logic [2:0] kind, logic [11:0] sz,
                                             logic [FieldW-1:0] addr);
    outcome_t    o;
    int unsigned a, h, nx, cur, steps, got;
    o = '0;
    a = 32'(addr);
    case (kind)
      ReqAlloc: begin
        o.ok = carve(32'(sz), got);
        o.raddr = got[FieldW-1:0];
      end
      ReqFree:     o.ok = release_blk(a);
      ReqFreeSafe: o.ok = on_chain(a) ? release_blk(a) : 1'b0;
      ReqMergeAll: o.ok = join_all();
      ReqMergeAt:  o.ok = join_at(a);
      ReqValidate: o.ok = on_chain(a);
      ReqInspect: begin
        o.inr = a < pool_span();
        if (a == 0) begin
          if (rover_at != 0) begin
            o.raddr = FieldW'(HeaderBytes);
            o.bsize = FieldW'(size_of(0));
            o.bfree = tag_of(0) == TagFree;
          end
        end else if (has_header(a)) begin
          h = a - HeaderBytes;
          nx = follow(h);
          o.bsize = FieldW'(size_of(h));
          o.bfree = tag_of(h) == TagFree;
          o.raddr = nx == rover_at ? '0 : FieldW'(nx + HeaderBytes);
        end
      end
      default: begin
        cur = 0;
        steps = 0;
        while (cur != rover_at && steps < PoolBytes) begin
          steps++;
          if (cur > rover_at) break;
          cur = follow(cur);
          o.cnt = o.cnt + 1'b1;
        end
      end
    endcase
    o.ftotal = avail_b[FieldW-1:0];
    o.rfree = rover_b[FieldW-1:0];
    return o;
  endfunction

  function automatic int unsigned chain_pick();
    int unsigned heads[$];
    int unsigned cur, steps;
    cur = 0;
    steps = 0;
    forever begin
      heads.push_back(cur + HeaderBytes);
      if (cur == rover_at || cur > rover_at || steps > PoolBytes) break;
      cur = follow(cur);
      steps++;
    end
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (ok_o !== w.ok) report("ok", ok_o, w.ok);
        if (result_addr_o !== w.raddr) report("result_addr", result_addr_o, w.raddr);
        if (block_size_o !== w.bsize) report("block_size", block_size_o, w.bsize);
        if (block_free_o !== w.bfree) report("block_free", block_free_o, w.bfree);
        if (in_range_o !== w.inr) report("in_range", in_range_o, w.inr);
        if (block_count_o !== w.cnt) report("block_count", block_count_o, w.cnt);
        if (free_total_o !== w.ftotal) report("free_total", free_total_o, w.ftotal);
        if (rover_free_o !== w.rfree) report("rover_free", rover_free_o, w.rfree);
      end
    end
  end

  task automatic send_request(logic [2:0] kind, logic [11:0] sz, logic [FieldW-1:0] addr);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_type_i <= kind;
    req_size_i <= sz;
    block_addr_i <= addr;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(apply_request(kind, sz, addr));
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0 || busy);
  endtask

  task automatic write_reg(logic idx, logic [FieldW-1:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPoolSize) begin
      pool_cfg = 32'(data);
      reinit_pool();
    end else begin
      merge_on = data[0];
    end
  endtask

  task automatic random_request();
    int unsigned r, ra;
    logic [2:0]  kind;
    logic [11:0] sz;
    r = $urandom_range(99);
    kind = r < 35 ? ReqAlloc : r < 55 ? ReqFree : r < 62 ? ReqFreeSafe :
           r < 66 ? ReqMergeAll : r < 74 ? ReqMergeAt : r < 82 ? ReqValidate :
           r < 92 ? ReqInspect : ReqCount;
    r = $urandom_range(99);
    sz = r < 70 ? 12'($urandom_range(1, 64)) : r < 95 ? 12'($urandom_range(65, 600)) :
         12'($urandom_range(0, 4095));
    r = $urandom_range(99);
    if (kind == ReqValidate || kind == ReqFreeSafe)
      ra = r < 50 ? chain_pick() : $urandom_range(0, 8191);
    else
      ra = r < 80 ? chain_pick() : r < 90 ? $urandom_range(0, 7) :
           $urandom_range(pool_span() + 1, 8191);
    send_request(kind, sz, FieldW'(ra));
  endtask

  task automatic test_random(int unsigned n, int unsigned pct);
    idle_pct = pct;
    repeat (n) random_request();
    settle();
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_request(ReqInspect, 0, 0);
    send_request(ReqCount, 0, 0);
    send_request(ReqAlloc, 0, 0);
    send_request(ReqAlloc, 12'hfff, 0);
    send_request(ReqMergeAt, 0, HeaderBytes);
    send_request(ReqAlloc, 100, 0);
    send_request(ReqAlloc, 16, 0);
    send_request(ReqAlloc, 40, 0);
    send_request(ReqInspect, 0, 0);
    send_request(ReqInspect, 0, HeaderBytes);
    send_request(ReqInspect, 0, 13'h1fff);
    send_request(ReqValidate, 0, 116);
    send_request(ReqValidate, 0, 117);
    send_request(ReqValidate, 0, 3);
    send_request(ReqValidate, 0, 13'h1fff);
    send_request(ReqFree, 0, HeaderBytes);
    send_request(ReqFreeSafe, 0, 116);
    send_request(ReqFreeSafe, 0, 50);
    send_request(ReqMergeAt, 0, 140);
    send_request(ReqMergeAll, 0, 0);
    send_request(ReqMergeAt, 0, HeaderBytes);
    send_request(ReqFree, 0, 13'h1fff);
    send_request(ReqAlloc, 30, 0);
    send_request(ReqAlloc, 60, 0);
    send_request(ReqCount, 0, 0);
    settle();
  endtask

  task automatic test_pressure();
    idle_pct = 31;
    repeat (4) begin
      repeat (50) random_request();
      settle();
    end
  endtask

  initial begin
    idle_pct = 0;
    start = 1'b0;
    req_type_i = ReqAlloc;
    req_size_i = '0;
    block_addr_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPoolSize;
    cfg_data_i = '0;
    pool_cfg = PoolBytes;
    merge_on = 1'b0;
    reinit_pool();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_reg(CfgAutoMerge, 13'd1);
    test_random(500, 0);
    write_reg(CfgPoolSize, 13'd16);
    test_random(60, 67);
    write_reg(CfgPoolSize, 13'd5);
    test_random(30, 0);
    write_reg(CfgPoolSize, 13'h1fff);
    write_reg(CfgAutoMerge, 13'd0);
    test_random(600, 67);
    write_reg(CfgPoolSize, 13'd512);
    test_random(400, 31);
    write_reg(CfgPoolSize, 13'd4096);
    write_reg(CfgAutoMerge, 13'h1fff);
    test_pressure();
    write_reg(CfgPoolSize, 13'd0);
    test_random(40, 67);

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
